// ===== sv/fdl_pkg.sv =====
// types, constants and saturation helper for the fractional delay line
package fdl_pkg;

  localparam int DEPTH       = 1024;
  localparam int FRAC_BITS   = 8;
  localparam int AW          = $clog2(DEPTH);
  localparam int PW          = AW + FRAC_BITS;
  localparam int SMP_W       = 20;
  localparam int DLY_W       = 18;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int PROD_W      = SMP_W + FRAC_BITS + 2;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [SMP_W:0]   wide_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_ENABLE  = 1'b0,
    REG_REPLACE_MODE = 1'b1
  } cfg_reg_t;

  localparam wide_t Q_ONE       = 21'sd32768;
  localparam wide_t Q_MINUS_ONE = -21'sd32768;
  localparam wide_t SMP_MIN     = -21'sd524288;
  localparam wide_t SMP_MAX     = 21'sd524287;

  function automatic smp_t sat(input wide_t v, input wide_t lo, input wide_t hi);
    wide_t r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r[SMP_W-1:0];
  endfunction

endpackage

// ===== sv/fractional_delay_line_core.sv =====
// fractional delay line: banked sample store, linear interpolation and write-back
// One beat in per clock; a beat is registered into the work stage and its result
// into the output register when that stage advances, and the input stalls only
// while the work stage waits on an output beat that has not been taken.
// Addresses are formed combinationally from the input beat and read from two banks
// (even and odd entries) so both interpolation neighbours come back together;
// each bank has a second read port for the entry under the write pointer. The next
// stage interpolates with one multiplier and writes back, with a bypass register
// covering the write that lands on the same edge as the following read. Entries not
// yet written read as zero, tracked by the write pointer and a wrap flag, so no
// clearing pass is needed after reset.
module fractional_delay_line_core import fdl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_in[19:0], delay_time[37:20], zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // delayed_out[19:0], zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic                   cfg_data
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  smp_t mem_even [DEPTH/2];
  smp_t mem_odd  [DEPTH/2];

  logic [AW-1:0] wp;
  logic          wrapped;
  logic          clip_enable;
  logic          replace_mode;

  logic          in_acc;
  smp_t          in_sample;
  logic [DLY_W-1:0] in_delay;
  logic [PW-1:0] rd_pos;
  logic [AW-1:0] ip;
  logic [AW-1:0] ipn;
  logic [AW-2:0] ev_addr;
  logic [AW-2:0] od_addr;

  smp_t ev_rd;
  smp_t od_rd;
  smp_t ev_old;
  smp_t od_old;

  logic                 s1_valid;
  logic                 s1_adv;
  smp_t                 s1_sample;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [AW-1:0]        s1_ip;
  logic [AW-1:0]        s1_ipn;
  logic [AW-1:0]        s1_wp;
  logic                 s1_prev_ok;
  logic                 s1_next_ok;
  logic                 s1_old_ok;

  logic          byp_valid;
  logic [AW-1:0] byp_addr;
  smp_t          byp_data;

  logic out_valid;
  smp_t out_data;

  smp_t prev_raw;
  smp_t next_raw;
  smp_t old_raw;
  smp_t prev_v;
  smp_t next_v;
  smp_t old_v;
  wide_t diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] step;
  wide_t res_w;
  smp_t  samp_c;
  wide_t sum;
  smp_t  wr_data;

  // input side
  assign in_sample     = s_axis_tdata[SMP_W-1:0];
  assign in_delay      = s_axis_tdata[SMP_W +: DLY_W];
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign rd_pos  = {wp, {FRAC_BITS{1'b0}}} - in_delay[PW-1:0];
  assign ip      = rd_pos[PW-1:FRAC_BITS];
  assign ipn     = ip + 1'b1;
  assign ev_addr = ip[0] ? ipn[AW-1:1] : ip[AW-1:1];
  assign od_addr = ip[0] ? ip[AW-1:1]  : ipn[AW-1:1];

  // sample store banks
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_rd  <= mem_even[ev_addr];
      ev_old <= mem_even[wp[AW-1:1]];
    end
    if (s1_adv && !s1_wp[0]) begin
      mem_even[s1_wp[AW-1:1]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      od_rd  <= mem_odd[od_addr];
      od_old <= mem_odd[wp[AW-1:1]];
    end
    if (s1_adv && s1_wp[0]) begin
      mem_odd[s1_wp[AW-1:1]] <= wr_data;
    end
  end

  // interpolate and write-back stage
  always_comb begin
    prev_raw = s1_ip[0] ? od_rd : ev_rd;
    next_raw = s1_ip[0] ? ev_rd : od_rd;
    old_raw  = s1_wp[0] ? od_old : ev_old;

    if (byp_valid && byp_addr == s1_ip) prev_v = byp_data;
    else                                prev_v = s1_prev_ok ? prev_raw : '0;
    if (byp_valid && byp_addr == s1_ipn) next_v = byp_data;
    else                                 next_v = s1_next_ok ? next_raw : '0;
    if (byp_valid && byp_addr == s1_wp) old_v = byp_data;
    else                                old_v = s1_old_ok ? old_raw : '0;
  end

  assign diff  = wide_t'(next_v) - wide_t'(prev_v);
  assign prod  = PROD_W'(diff) * PROD_W'($signed({1'b0, s1_frac}));
  assign rnd   = prod + RND_HALF;
  assign step  = rnd >>> FRAC_BITS;
  assign res_w = wide_t'(prev_v) + step[SMP_W:0];

  always_comb begin
    samp_c = clip_enable ? sat(wide_t'(s1_sample), Q_MINUS_ONE, Q_ONE) : s1_sample;
    sum    = wide_t'(old_v) + wide_t'(samp_c);
    if (replace_mode)     wr_data = samp_c;
    else if (clip_enable) wr_data = sat(sum, Q_MINUS_ONE, Q_ONE);
    else                  wr_data = sat(sum, SMP_MIN, SMP_MAX);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      wrapped      <= 1'b0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      byp_valid    <= 1'b0;
      clip_enable  <= 1'b1;
      replace_mode <= 1'b1;
    end else begin
      if (in_acc) begin
        wp <= wp + 1'b1;
        if (wp == AW'(DEPTH - 1)) wrapped <= 1'b1;
      end
      if (in_acc)      s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv)             out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      if (s1_adv) byp_valid <= 1'b1;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CLIP_ENABLE:  clip_enable  <= cfg_data;
          REG_REPLACE_MODE: replace_mode <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample  <= in_sample;
      s1_frac    <= rd_pos[FRAC_BITS-1:0];
      s1_ip      <= ip;
      s1_ipn     <= ipn;
      s1_wp      <= wp;
      s1_prev_ok <= wrapped || (ip < wp);
      s1_next_ok <= wrapped || (ipn < wp);
      s1_old_ok  <= wrapped;
    end
    if (s1_adv) begin
      out_data <= res_w[SMP_W-1:0];
      byp_addr <= s1_wp;
      byp_data <= wr_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - SMP_W){1'b0}}, out_data};

`ifndef ASSERT_OFF
  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> wp == AW'($past(wp) + 1'b1))
    else $error("write pointer did not advance by one beat");

  a_wrap_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(wrapped) |-> wp == '0)
    else $error("wrap flag set away from pointer zero");

  a_byp_tracks_write: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> byp_valid && byp_addr == $past(s1_wp))
    else $error("bypass register missed a store write");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_axis_tready)
    else $error("input stalled with empty work stage");
`endif

endmodule
